### rtl/core/hdlg_pkg.sv
// ----------------------------------------------------------------------------
// Detail level governor package
// Shared types, register indexes, level and mode codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlg_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOD_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_FPS      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE_FPS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_COUNT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE_COUNT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_ZOOM     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_ZOOM   = 4'd7;

  localparam logic [1:0] LVL_FULL   = 2'd0;
  localparam logic [1:0] LVL_MEDIUM = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  localparam logic [1:0] MODE_AUTO = 2'd0;

  localparam logic [7:0] RUN_MAX = 8'd255;

  localparam logic [1:0]  RST_LOD_MODE      = MODE_AUTO;
  localparam logic [15:0] RST_DROP_FPS      = 16'd560;
  localparam logic [15:0] RST_RESTORE_FPS   = 16'd880;
  localparam logic [7:0]  RST_DROP_COUNT    = 8'd30;
  localparam logic [7:0]  RST_RESTORE_COUNT = 8'd90;
  localparam logic [1:0]  RST_START_LEVEL   = LVL_FULL;
  localparam logic [15:0] RST_FULL_ZOOM     = 16'd3482;
  localparam logic [15:0] RST_MEDIUM_ZOOM   = 16'd1229;

  typedef struct packed {
    logic [15:0] fps_sample;
    logic        sample_valid;
    logic [15:0] zoom_factor;
  } in_item_t;

  typedef struct packed {
    logic [1:0] effective_level;
    logic [1:0] auto_limit_level;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  lod_mode;
    logic [15:0] drop_fps_threshold;
    logic [15:0] restore_fps_threshold;
    logic [7:0]  drop_sample_count;
    logic [7:0]  restore_sample_count;
    logic [1:0]  auto_start_level;
    logic [15:0] full_zoom_threshold;
    logic [15:0] medium_zoom_threshold;
  } cfg_t;

  typedef struct packed {
    logic       reload;
    logic [1:0] start_level;
  } reload_t;

  typedef struct packed {
    logic [1:0] auto_limit;
    logic [7:0] low_run;
    logic [7:0] high_run;
  } gov_state_t;

  function automatic logic [1:0] clamp_level(input logic [1:0] v);
    return (v > LVL_LOW) ? LVL_LOW : v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hdlg_cfg.sv
// ----------------------------------------------------------------------------
// Detail level governor configuration registers
// Holds the eight settings and flags a governor state reload on a write to one.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlg_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [hdlg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hdlg_pkg::CFG_DATA_W-1:0] cfg_data,
  output hdlg_pkg::cfg_t                     cfg,
  output hdlg_pkg::reload_t                  reload
);

  hdlg_pkg::cfg_t cfg_next;
  logic           hit;

  always_comb begin
    cfg_next = cfg;
    hit      = 1'b1;
    unique case (cfg_index)
      hdlg_pkg::REG_LOD_MODE:      cfg_next.lod_mode              = cfg_data[1:0];
      hdlg_pkg::REG_DROP_FPS:      cfg_next.drop_fps_threshold    = cfg_data;
      hdlg_pkg::REG_RESTORE_FPS:   cfg_next.restore_fps_threshold = cfg_data;
      hdlg_pkg::REG_DROP_COUNT:    cfg_next.drop_sample_count     = cfg_data[7:0];
      hdlg_pkg::REG_RESTORE_COUNT: cfg_next.restore_sample_count  = cfg_data[7:0];
      hdlg_pkg::REG_START_LEVEL:   cfg_next.auto_start_level      = cfg_data[1:0];
      hdlg_pkg::REG_FULL_ZOOM:     cfg_next.full_zoom_threshold   = cfg_data;
      hdlg_pkg::REG_MEDIUM_ZOOM:   cfg_next.medium_zoom_threshold = cfg_data;
      default:                     hit                            = 1'b0;
    endcase
  end

  assign reload.reload      = cfg_we && hit;
  assign reload.start_level = hdlg_pkg::clamp_level(cfg_next.auto_start_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lod_mode              <= hdlg_pkg::RST_LOD_MODE;
      cfg.drop_fps_threshold    <= hdlg_pkg::RST_DROP_FPS;
      cfg.restore_fps_threshold <= hdlg_pkg::RST_RESTORE_FPS;
      cfg.drop_sample_count     <= hdlg_pkg::RST_DROP_COUNT;
      cfg.restore_sample_count  <= hdlg_pkg::RST_RESTORE_COUNT;
      cfg.auto_start_level      <= hdlg_pkg::RST_START_LEVEL;
      cfg.full_zoom_threshold   <= hdlg_pkg::RST_FULL_ZOOM;
      cfg.medium_zoom_threshold <= hdlg_pkg::RST_MEDIUM_ZOOM;
    end else if (reload.reload) begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hdlg_step.sv
// ----------------------------------------------------------------------------
// Detail level governor step logic
// Run counter hysteresis, auto limit stepping and final level selection.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlg_step (
  input  wire hdlg_pkg::cfg_t       cfg,
  input  wire hdlg_pkg::gov_state_t state,
  input  wire hdlg_pkg::in_item_t   item,
  output hdlg_pkg::gov_state_t state_next,
  output hdlg_pkg::out_item_t result
);

  logic [7:0] drop_cnt;
  logic [7:0] restore_cnt;
  logic [7:0] low_run;
  logic [7:0] high_run;
  logic [1:0] limit;
  logic [1:0] zoom_level;
  logic [1:0] mode_limit;

  assign drop_cnt    = (cfg.drop_sample_count == 8'd0) ? 8'd1 : cfg.drop_sample_count;
  assign restore_cnt = (cfg.restore_sample_count == 8'd0) ? 8'd1 :
                       cfg.restore_sample_count;

  always_comb begin
    low_run  = 8'd0;
    high_run = 8'd0;
    limit    = state.auto_limit;
    if (cfg.lod_mode == hdlg_pkg::MODE_AUTO && item.sample_valid &&
        item.fps_sample != 16'd0) begin
      if (item.fps_sample < cfg.drop_fps_threshold) begin
        low_run = (state.low_run == hdlg_pkg::RUN_MAX) ? hdlg_pkg::RUN_MAX :
                  state.low_run + 8'd1;
      end else if (item.fps_sample > cfg.restore_fps_threshold) begin
        high_run = (state.high_run == hdlg_pkg::RUN_MAX) ? hdlg_pkg::RUN_MAX :
                   state.high_run + 8'd1;
      end
      if (low_run >= drop_cnt && state.auto_limit != hdlg_pkg::LVL_LOW) begin
        limit   = state.auto_limit + 2'd1;
        low_run = 8'd0;
      end else if (high_run >= restore_cnt && state.auto_limit != hdlg_pkg::LVL_FULL) begin
        limit    = state.auto_limit - 2'd1;
        high_run = 8'd0;
      end
    end
  end

  always_comb begin
    if (item.zoom_factor >= cfg.full_zoom_threshold) begin
      zoom_level = hdlg_pkg::LVL_FULL;
    end else if (item.zoom_factor >= cfg.medium_zoom_threshold) begin
      zoom_level = hdlg_pkg::LVL_MEDIUM;
    end else begin
      zoom_level = hdlg_pkg::LVL_LOW;
    end
  end

  assign mode_limit = (cfg.lod_mode == hdlg_pkg::MODE_AUTO) ? limit : cfg.lod_mode - 2'd1;

  assign state_next.auto_limit = limit;
  assign state_next.low_run    = low_run;
  assign state_next.high_run   = high_run;

  assign result.effective_level  = (zoom_level > mode_limit) ? zoom_level : mode_limit;
  assign result.auto_limit_level = limit;

endmodule

`default_nettype wire

### rtl/core/hysteresis_detail_level_governor.sv
// ----------------------------------------------------------------------------
// Hysteresis detail level governor
// Picks a detail level per frame from the rate sample, zoom and mode.
// ----------------------------------------------------------------------------
// A request is captured in the input register, and once the result register
// is free or being read, the step logic updates the run counters and auto
// limit and loads the result register. Throughput is one request per clock,
// limited only by the output side taking results. Configuration writes take
// effect on the next cycle.
`default_nettype none

module hysteresis_detail_level_governor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [hdlg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hdlg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire hdlg_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output hdlg_pkg::out_item_t                out_data
);

  hdlg_pkg::cfg_t      cfg;
  hdlg_pkg::reload_t   reload;
  hdlg_pkg::gov_state_t state;
  hdlg_pkg::gov_state_t state_next;
  hdlg_pkg::in_item_t  item;
  hdlg_pkg::out_item_t result;
  logic                item_valid;
  logic                advance;

  hdlg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .reload    (reload)
  );

  hdlg_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid       <= 1'b0;
      out_valid        <= 1'b0;
      state.auto_limit <= hdlg_pkg::LVL_FULL;
      state.low_run    <= 8'd0;
      state.high_run   <= 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
        item       <= in_data;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (reload.reload) begin
        state.auto_limit <= reload.start_level;
        state.low_run    <= 8'd0;
        state.high_run   <= 8'd0;
      end else if (advance) begin
        state <= state_next;
      end
    end
  end

  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    state.auto_limit != 2'd3)
    else $error("auto limit left the level range");

  a_reload_clears: assert property (@(posedge clk) disable iff (rst)
    reload.reload |=> (state.low_run == 8'd0 && state.high_run == 8'd0))
    else $error("run counters not cleared by a configuration write");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> (item_valid && $stable(item)))
    else $error("stalled request lost from the input register");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> item_valid)
    else $error("accepted request not captured");

  a_eff_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.effective_level != 2'd3)
    else $error("effective level out of range");

endmodule

`default_nettype wire
